// File: src/line_position_steer_core_defines.svh
// assertion macros shared by the line position steering rtl
`ifndef LINE_POSITION_STEER_CORE_DEFINES_SVH
`define LINE_POSITION_STEER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lps check failed");

// next-cycle implication, disabled while in reset
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lps check failed");

`endif

// File: src/lps_pkg.sv
// shared constants and register codes for the line position steering core
package lps_pkg;

  localparam int RowPixelsDefault = 320;

  localparam int BrightW  = 8;
  localparam int TapeW    = 13;
  localparam int SpeedInW = 8;
  localparam int GainW    = 16;
  localparam int SpeedW   = 9;
  localparam int ErrW     = 15;

  localparam int ErrMax = 16383;
  localparam int ErrMin = -16384;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [BrightW-1:0]  ThresholdReset = 8'd100;
  localparam logic [TapeW-1:0]    TapeWidthReset = 13'd60;
  localparam logic [SpeedInW-1:0] BaseSpeedReset = 8'd40;
  localparam logic [SpeedInW-1:0] LimitReset     = 8'd150;
  localparam logic [GainW-1:0]    GainReset      = 16'd177;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 3'd0,
    CfgTapeWidth = 3'd1,
    CfgBaseSpeed = 3'd2,
    CfgLimit     = 3'd3,
    CfgGain      = 3'd4
  } cfg_reg_e;

endpackage

// File: src/line_position_steer_core.sv
// line position steering core: per-row centroid error and wheel speed steering
//
// Pixels of one camera row stream in on the input channel, one item per cycle
// (brightness_i, last_pixel_i), accepted when in_valid_i is high and in_stall_o
// low. A pixel brighter than the threshold is white and adds its signed weight
// (position minus half the row) to a running sum and one to a white count.
// Pixels beyond ROW_PIXELS are ignored. The item carrying last_pixel_i closes
// the row and causes exactly one result on the output channel; other items
// cause none. A result is taken when out_valid_o is high and out_stall_i low.
// The edge that accepts the last pixel saturates the sum into the row closing stage;
// gain and clamp then fill the result register, which drives out_valid_o.
// Throughput: one pixel per cycle while in_stall_o is low, set by the accumulator update.
// A stalled result holds; the block keeps taking pixels until its row closing
// stage is also full, then raises in_stall_o.
// Configuration registers are written over cfg_valid_i/cfg_ready_o with
// cfg_index_i and cfg_data_i; cfg_ready_o is always high. The user must write
// only while the block is idle; the block itself does not enforce this.
// Reset clears the row accumulators, empties the pipeline and loads the
// default register values.
module line_position_steer_core #(
  parameter int ROW_PIXELS = lps_pkg::RowPixelsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lps_pkg::BrightW-1:0]    brightness_i,
  input  logic                           last_pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [lps_pkg::SpeedW-1:0] left_speed_o,
  output logic signed [lps_pkg::SpeedW-1:0] right_speed_o,
  output logic                           reversing_o,
  output logic signed [lps_pkg::ErrW-1:0] line_error_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lps_pkg::CfgDataW-1:0]   cfg_data_i
);

  `include "line_position_steer_core_defines.svh"

  localparam int PosW  = $clog2(ROW_PIXELS + 1);
  localparam int SumW0 = 2 * $clog2(ROW_PIXELS) + 2;
  localparam int SumW  = (SumW0 > 16) ? SumW0 : 16;
  localparam int CmpW  = (PosW + 1 > lps_pkg::TapeW) ? PosW + 1 : lps_pkg::TapeW;
  localparam int AccW  = 18;

  localparam logic [PosW-1:0]        RowLen  = PosW'(ROW_PIXELS);
  localparam logic signed [SumW-1:0] HalfRow = SumW'(ROW_PIXELS / 2);
  localparam logic signed [SumW-1:0] SatMax  = SumW'(lps_pkg::ErrMax);
  localparam logic signed [SumW-1:0] SatMin  = SumW'(lps_pkg::ErrMin);

  // configuration registers
  logic [lps_pkg::BrightW-1:0]  thr_q;
  logic [lps_pkg::TapeW-1:0]    tape_q;
  logic [lps_pkg::SpeedInW-1:0] base_q;
  logic [lps_pkg::SpeedInW-1:0] lim_q;
  logic [lps_pkg::GainW-1:0]    gain_q;

  // row accumulators
  logic [PosW-1:0]        pos_q, pos_d;
  logic [PosW-1:0]        cnt_q, cnt_d;
  logic signed [SumW-1:0] sum_q, sum_d;

  // row closing stage
  logic                          s1_valid_q;
  logic signed [lps_pkg::ErrW-1:0] s1_err_q, s1_err_d;
  logic                          s1_rev_q, s1_rev_d;

  // result register
  logic                           out_valid_q;
  logic signed [lps_pkg::SpeedW-1:0] left_q, left_d;
  logic signed [lps_pkg::SpeedW-1:0] right_q, right_d;
  logic                           rev_q;
  logic signed [lps_pkg::ErrW-1:0] err_q;

  logic in_acc, close_row, out_free, s1_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;
  assign close_row  = in_acc && last_pixel_i;

  assign cfg_ready_o = 1'b1;

  // accumulate this pixel and form the closed row values
  logic                   in_range, is_white;
  logic signed [SumW-1:0] weight, sum_next;
  logic [PosW-1:0]        cnt_next;
  logic [CmpW-1:0]        twice_cnt;

  always_comb begin
    in_range  = pos_q < RowLen;
    is_white  = brightness_i > thr_q;
    weight    = $signed(SumW'(pos_q)) - HalfRow;
    sum_next  = sum_q;
    cnt_next  = cnt_q;
    pos_d     = pos_q;
    if (in_range) begin
      pos_d = pos_q + 1'b1;
      if (is_white) begin
        sum_next = sum_q + weight;
        cnt_next = cnt_q + 1'b1;
      end
    end
    sum_d = sum_next;
    cnt_d = cnt_next;
    if (last_pixel_i) begin
      pos_d = '0;
      sum_d = '0;
      cnt_d = '0;
    end
    if (sum_next > SatMax) begin
      s1_err_d = lps_pkg::ErrW'(SatMax);
    end else if (sum_next < SatMin) begin
      s1_err_d = lps_pkg::ErrW'(SatMin);
    end else begin
      s1_err_d = lps_pkg::ErrW'(sum_next);
    end
    twice_cnt = CmpW'({cnt_next, 1'b0});
    s1_rev_d  = twice_cnt < CmpW'(tape_q);
  end

  // gain multiply and speed clamp
  function automatic logic signed [lps_pkg::SpeedW-1:0] clamp_speed(
    logic signed [AccW-1:0] v,
    logic [lps_pkg::SpeedInW-1:0] lim
  );
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] r;
    hi = $signed(AccW'(lim));
    if (v > hi) begin
      r = hi;
    end else if (v < -hi) begin
      r = -hi;
    end else begin
      r = v;
    end
    return lps_pkg::SpeedW'(r);
  endfunction

  logic [15:0]            err_ext, mag;
  logic [31:0]            prod;
  logic signed [AccW-1:0] steer, bias, left_raw, right_raw;

  always_comb begin
    err_ext = 16'($signed(s1_err_q));
    mag     = s1_err_q[lps_pkg::ErrW-1] ? (~err_ext + 16'd1) : err_ext;
    prod    = mag * gain_q;
    steer   = $signed(AccW'(prod[31:16]));
    if (s1_err_q[lps_pkg::ErrW-1]) begin
      steer = -steer;
    end
    bias = $signed(AccW'(base_q));
    if (s1_rev_q) begin
      bias  = -bias;
      steer = '0;
    end
    left_raw  = bias + steer;
    right_raw = bias - steer;
    left_d    = clamp_speed(left_raw, lim_q);
    right_d   = clamp_speed(right_raw, lim_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= lps_pkg::ThresholdReset;
      tape_q      <= lps_pkg::TapeWidthReset;
      base_q      <= lps_pkg::BaseSpeedReset;
      lim_q       <= lps_pkg::LimitReset;
      gain_q      <= lps_pkg::GainReset;
      pos_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (lps_pkg::cfg_reg_e'(cfg_index_i))
          lps_pkg::CfgThreshold: thr_q  <= cfg_data_i[lps_pkg::BrightW-1:0];
          lps_pkg::CfgTapeWidth: tape_q <= cfg_data_i[lps_pkg::TapeW-1:0];
          lps_pkg::CfgBaseSpeed: base_q <= cfg_data_i[lps_pkg::SpeedInW-1:0];
          lps_pkg::CfgLimit:     lim_q  <= cfg_data_i[lps_pkg::SpeedInW-1:0];
          lps_pkg::CfgGain:      gain_q <= cfg_data_i[lps_pkg::GainW-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        pos_q <= pos_d;
        cnt_q <= cnt_d;
        sum_q <= sum_d;
      end
      if (s1_free) begin
        s1_valid_q <= close_row;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_row) begin
      s1_err_q <= s1_err_d;
      s1_rev_q <= s1_rev_d;
    end
    if (out_free && s1_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      rev_q   <= s1_rev_q;
      err_q   <= s1_err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign reversing_o   = rev_q;
  assign line_error_o  = err_q;

  `LPS_ASSERT_NOW(a_rev_same_speed, clk_i, rst_ni,
    out_valid_o && reversing_o, left_speed_o == right_speed_o)
  `LPS_ASSERT_NEXT(a_row_cleared, clk_i, rst_ni,
    in_acc && last_pixel_i, pos_q == '0 && cnt_q == '0 && sum_q == '0)
  `LPS_ASSERT_NOW(a_count_le_pos, clk_i, rst_ni, 1'b1, cnt_q <= pos_q && pos_q <= RowLen)
  `LPS_ASSERT_NEXT(a_s1_held, clk_i, rst_ni, s1_valid_q && !out_free, s1_valid_q)

endmodule
